@@ sv/upd_pkg.sv @@
// Shared types, constants and helpers for the URL percent decoder.
// No dependencies; the front end, back end, top level and testbench import this package.
`default_nettype none

package upd_pkg;

    // Default width of the per-message written-byte counter
    localparam int C_COUNT_BITS = 16;
    // Depth of the front-to-back command queue and of the result queue
    localparam int C_CMD_DEPTH  = 4;
    localparam int C_RES_DEPTH  = 4;

    // Limit register reset value
    localparam logic [15:0] C_MAX_OUT_RESET = 16'hFFFF;

    // Character codes
    localparam logic [7:0] C_CHAR_PCT   = 8'h25;  // '%'
    localparam logic [7:0] C_CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] C_CHAR_SPACE = 8'h20;  // ' '
    localparam logic [7:0] C_CHAR_W     = 8'h57;  // 'W', 'a' - 10
    localparam logic [7:0] C_CASE_BIT   = 8'h20;  // upper to lower case

    // Escape sequence state
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PCT,
        ESC_DIGIT
    } t_esc_phase;

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_upd_in;

    // Result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        msg_end;
        logic        was_truncated;
        logic [15:0] decoded_length;
    } t_upd_out;

    // Classified item: up to three candidate bytes in order, plus end flag
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } t_upd_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Value of a hex digit; only meaningful when is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else begin
            v = (c | C_CASE_BIT) - C_CHAR_W;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/upd_fifo.sv @@
// Small first-word-fall-through queue built from flops.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module upd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

@@ sv/upd_front.sv @@
// Front end: tracks escape sequences and turns each input byte into a
// command of up to three candidate bytes. Depends on upd_pkg.
`default_nettype none

module upd_front import upd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_upd_in i_data,
    output logic         o_full,
    input  wire logic    i_cmd_full,
    output logic         o_cmd_push,
    output t_upd_cmd     o_cmd
);

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_esc_phase w_mid_phase;
    logic [7:0] w_mid_held;
    logic       w_accept;
    logic [7:0] w_c;
    logic       w_hex;

    assign o_full     = i_cmd_full;
    assign w_accept   = i_push && !i_cmd_full;
    assign o_cmd_push = w_accept;
    assign w_c        = i_data.in_byte;
    assign w_hex      = is_hex(w_c);

    // Next state: phase after this byte, then cleared at message end
    always_comb begin
        w_mid_phase = ESC_IDLE;
        w_mid_held  = r_held;
        unique case (r_phase)
            ESC_PCT: begin
                if (w_hex) begin
                    w_mid_phase = ESC_DIGIT;
                    w_mid_held  = w_c;
                end else if (w_c == C_CHAR_PCT) begin
                    w_mid_phase = ESC_PCT;
                end
            end
            ESC_DIGIT: begin
                if (!w_hex && w_c == C_CHAR_PCT) begin
                    w_mid_phase = ESC_PCT;
                end
            end
            default: begin
                if (w_c == C_CHAR_PCT) begin
                    w_mid_phase = ESC_PCT;
                end
            end
        endcase

        n_phase = r_phase;
        n_held  = r_held;
        if (w_accept) begin
            n_phase = i_data.in_last ? ESC_IDLE : w_mid_phase;
            n_held  = i_data.in_last ? 8'h00 : w_mid_held;
        end
    end

    // Outputs: candidate bytes in emission order
    always_comb begin
        logic [1:0] k;
        logic       plain;
        k     = 2'd0;
        plain = 1'b0;
        o_cmd = '0;
        unique case (r_phase)
            ESC_PCT: begin
                if (!w_hex) begin
                    o_cmd.bytes[k] = C_CHAR_PCT;
                    k = k + 2'd1;
                    plain = 1'b1;
                end
            end
            ESC_DIGIT: begin
                if (w_hex) begin
                    o_cmd.bytes[k] = {hex_val(r_held), hex_val(w_c)};
                    k = k + 2'd1;
                end else begin
                    o_cmd.bytes[k] = C_CHAR_PCT;
                    k = k + 2'd1;
                    o_cmd.bytes[k] = r_held;
                    k = k + 2'd1;
                    plain = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        // Byte handled as a fresh byte; '%' only opens an escape
        if (plain && w_c != C_CHAR_PCT && k != 2'd3) begin
            o_cmd.bytes[k] = (w_c == C_CHAR_PLUS) ? C_CHAR_SPACE : w_c;
            k = k + 2'd1;
        end

        // Flush a pending escape literally at message end
        if (i_data.in_last && w_mid_phase != ESC_IDLE && k != 2'd3) begin
            o_cmd.bytes[k] = C_CHAR_PCT;
            k = k + 2'd1;
            if (w_mid_phase == ESC_DIGIT && k != 2'd3) begin
                o_cmd.bytes[k] = w_mid_held;
                k = k + 2'd1;
            end
        end

        o_cmd.count = k;
        o_cmd.last  = i_data.in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_held  <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.in_last) |=> (r_phase == ESC_IDLE && r_held == 8'h00))
        else $error("escape state not cleared after message end");
    a_no_bytes_on_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_data.in_last && r_phase == ESC_IDLE && w_c == C_CHAR_PCT)
        |-> (o_cmd.count == 2'd0))
        else $error("opening percent produced output");
`endif

endmodule

`default_nettype wire

@@ sv/upd_back.sv @@
// Back end: applies the byte limit to queued commands one candidate per cycle
// while the result queue has room, counts kept bytes, builds results. Uses upd_pkg.
`default_nettype none

module upd_back import upd_pkg::*; #(
    parameter int COUNT_BITS = C_COUNT_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_max_out,
    input  wire t_upd_cmd    i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    input  wire logic        i_res_full,
    output logic             o_res_push,
    output t_upd_out         o_res
);

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [1:0]            r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_written, n_written;
    logic                  r_dropped, n_dropped;
    logic                  r_any_kept, n_any_kept;

    logic [LW-1:0]         w_limit, w_max_ext, w_cap_ext, w_written_ext;
    logic [COUNT_BITS-1:0] w_written_inc;
    logic                  w_step, w_has_cand, w_final, w_keep, w_next_keep;
    logic [7:0]            w_byte;

    // Effective limit: register value capped by counter capacity
    assign w_max_ext     = LW'(i_max_out);
    assign w_cap_ext     = LW'({COUNT_BITS{1'b1}});
    assign w_limit       = (w_max_ext < w_cap_ext) ? w_max_ext : w_cap_ext;
    assign w_written_ext = LW'(r_written);
    assign w_written_inc = r_written + COUNT_BITS'(1);
    assign w_keep        = w_written_ext < w_limit;
    assign w_next_keep   = LW'(w_written_inc) < w_limit;

    assign w_step     = !i_cmd_empty && !i_res_full;
    assign w_has_cand = (i_cmd.count != 2'd0);
    assign w_final    = !w_has_cand || (r_idx == i_cmd.count - 2'd1);
    assign w_byte     = i_cmd.bytes[r_idx];
    assign o_cmd_pop  = w_step && w_final;

    // Result build and counter update for one candidate
    always_comb begin
        n_idx      = r_idx;
        n_written  = r_written;
        n_dropped  = r_dropped;
        n_any_kept = r_any_kept;
        o_res_push = 1'b0;
        o_res      = '0;

        if (w_step) begin
            if (w_has_cand && w_keep) begin
                o_res_push       = 1'b1;
                o_res.out_byte   = w_byte;
                o_res.byte_valid = 1'b1;
                // Kept bytes form a prefix, so this is the last one when
                // the command ends here or the next one would be dropped
                if (i_cmd.last && (w_final || !w_next_keep)) begin
                    o_res.msg_end        = 1'b1;
                    o_res.was_truncated  = r_dropped || !w_final;
                    o_res.decoded_length = 16'(LW'(w_written_inc));
                end
                n_written  = w_written_inc;
                n_any_kept = 1'b1;
            end else if (w_has_cand) begin
                n_dropped = 1'b1;
                if (w_final && i_cmd.last && !r_any_kept) begin
                    o_res_push           = 1'b1;
                    o_res.msg_end        = 1'b1;
                    o_res.was_truncated  = 1'b1;
                    o_res.decoded_length = 16'(w_written_ext);
                end
            end else if (i_cmd.last) begin
                // End-only marker
                o_res_push           = 1'b1;
                o_res.msg_end        = 1'b1;
                o_res.was_truncated  = r_dropped;
                o_res.decoded_length = 16'(w_written_ext);
            end

            if (w_final) begin
                n_idx      = 2'd0;
                n_any_kept = 1'b0;
                if (i_cmd.last) begin
                    n_written = '0;
                    n_dropped = 1'b0;
                end
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= 2'd0;
            r_written  <= '0;
            r_dropped  <= 1'b0;
            r_any_kept <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_written  <= n_written;
            r_dropped  <= n_dropped;
            r_any_kept <= n_any_kept;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.last) |=> (r_written == '0 && !r_dropped))
        else $error("message counters not cleared at message end");
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !o_res.byte_valid) |-> (o_res.msg_end && o_res.out_byte == 8'h00))
        else $error("end-only marker without message end");
    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd_empty && w_has_cand) |-> (r_idx < i_cmd.count))
        else $error("candidate index past command length");
`endif

endmodule

`default_nettype wire

@@ sv/url_percent_decoder_top.sv @@
// Top level of the URL percent decoder: front end, command queue, back end,
// result queue and the limit register. Depends on upd_pkg and all submodules.
// A byte's results pass through the command queue and then the result queue.
// Throughput: one byte per cycle while each byte yields at most one candidate
// byte and the result queue has room; more candidates hold the back end longer.
// Reset (synchronous, active low): clears escape state, counters and both
// queues, and sets the byte limit to 65535.
`default_nettype none

module url_percent_decoder_top import upd_pkg::*; #(
    parameter int COUNT_BITS = C_COUNT_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire t_upd_in     i_data,
    output logic             full,
    input  wire logic        pop,
    output t_upd_out         o_data,
    output logic             empty,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    logic [15:0] r_max_out;
    t_upd_cmd    w_cmd_in, w_cmd_out;
    logic        w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;
    t_upd_out    w_res;
    logic        w_res_push, w_res_full;

    // Byte limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= C_MAX_OUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_out <= i_cfg_wr_data;
        end
    end

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .o_full     (full),
        .i_cmd_full (w_cmd_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    upd_fifo #(
        .WIDTH ($bits(t_upd_cmd)),
        .DEPTH (C_CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    upd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_out   (r_max_out),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    upd_fifo #(
        .WIDTH ($bits(t_upd_out)),
        .DEPTH (C_RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for url_percent_decoder_top: directed and random byte streams,
// with a predictor of the decoder and a scoreboard on the result queue.
// Depends on upd_pkg and the decoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 50;

    // DUT connections, inputs at known values from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    t_upd_in     i_data        = '0;
    logic        full;
    logic        pop           = 1'b0;
    t_upd_out    o_data;
    logic        empty;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    // Decoder predictor state
    t_esc_phase  pred_phase    = ESC_IDLE;
    logic [7:0]  pred_held     = '0;
    logic [15:0] pred_written  = '0;
    logic        pred_dropped  = 1'b0;
    logic [15:0] pred_limit    = C_MAX_OUT_RESET;
    t_upd_out    step_results[3];
    int          step_count;

    // Decoded results still owed by the DUT, oldest first
    t_upd_out    pending_decodes[$];

    int errors          = 0;
    int bytes_sent      = 0;
    int messages_sent   = 0;
    int results_checked = 0;
    int limit_writes    = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;

    url_percent_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .i_data        (i_data),
        .full          (full),
        .pop           (pop),
        .o_data        (o_data),
        .empty         (empty),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- error reporting ----------------

    task automatic report_error(input string msg);
        if (errors < 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            report_error($sformatf("result %0d field %s: expected 0x%0h, got 0x%0h",
                                   results_checked, name, want, got));
        end
    endtask

    // ---------------- predictor ----------------

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c inside {["0":"9"]}) || (c inside {["a":"f"]}) || (c inside {["A":"F"]});
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {["a":"f"]}) begin
            v = c - "a" + 8'd10;
        end else if (c inside {["A":"F"]}) begin
            v = c - "A" + 8'd10;
        end else begin
            v = c - "0";
        end
        return v[3:0];
    endfunction

    // Keep a decoded byte while under the limit and under three per step
    function automatic void keep_decoded(input logic [7:0] b);
        if (pred_written < pred_limit && step_count < 3) begin
            step_results[step_count] = '0;
            step_results[step_count].out_byte   = b;
            step_results[step_count].byte_valid = 1'b1;
            step_count++;
            pred_written++;
        end else begin
            pred_dropped = 1'b1;
        end
    endfunction

    function automatic void decode_plain(input logic [7:0] c);
        if (c == C_CHAR_PCT) begin
            pred_phase = ESC_PCT;
        end else if (c == C_CHAR_PLUS) begin
            keep_decoded(C_CHAR_SPACE);
        end else begin
            keep_decoded(c);
        end
    endfunction

    // One accepted byte: advance the predictor, queue what it yields
    function automatic void predict_decode(input logic [7:0] c, input logic last);
        step_count = 0;
        case (pred_phase)
            ESC_PCT: begin
                if (is_hex_char(c)) begin
                    pred_held  = c;
                    pred_phase = ESC_DIGIT;
                end else begin
                    pred_phase = ESC_IDLE;
                    keep_decoded(C_CHAR_PCT);
                    decode_plain(c);
                end
            end
            ESC_DIGIT: begin
                pred_phase = ESC_IDLE;
                if (is_hex_char(c)) begin
                    keep_decoded({nibble_of(pred_held), nibble_of(c)});
                end else begin
                    keep_decoded(C_CHAR_PCT);
                    keep_decoded(pred_held);
                    decode_plain(c);
                end
            end
            default: begin
                pred_phase = ESC_IDLE;
                decode_plain(c);
            end
        endcase

        // end of message: flush a pending escape, then tag the final result
        if (last) begin
            if (pred_phase == ESC_PCT) begin
                keep_decoded(C_CHAR_PCT);
            end else if (pred_phase == ESC_DIGIT) begin
                keep_decoded(C_CHAR_PCT);
                keep_decoded(pred_held);
            end
            if (step_count == 0) begin
                step_results[0] = '0;
                step_count = 1;
            end
            step_results[step_count-1].msg_end        = 1'b1;
            step_results[step_count-1].was_truncated  = pred_dropped;
            step_results[step_count-1].decoded_length = pred_written;
            pred_phase   = ESC_IDLE;
            pred_held    = '0;
            pred_written = '0;
            pred_dropped = 1'b0;
        end

        for (int i = 0; i < step_count; i++) begin
            pending_decodes.push_back(step_results[i]);
        end
    endfunction

    // ---------------- result side ----------------

    // Check every result transfer against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_upd_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_decodes.size() == 0) begin
                report_error($sformatf("unexpected result byte 0x%0h valid %0b end %0b",
                                       o_data.out_byte, o_data.byte_valid, o_data.msg_end));
            end else begin
                want = pending_decodes.pop_front();
                check_field("out_byte",       want.out_byte,       o_data.out_byte);
                check_field("byte_valid",     want.byte_valid,     o_data.byte_valid);
                check_field("msg_end",        want.msg_end,        o_data.msg_end);
                check_field("was_truncated",  want.was_truncated,  o_data.was_truncated);
                check_field("decoded_length", want.decoded_length, o_data.decoded_length);
                results_checked++;
            end
        end
    end

    // Receiver: alternates free-running stretches with stretches of random stalls
    always @(posedge i_clk) begin : drive_pop
        static int  stretch_left = 0;
        static bit  free_running = 1'b0;
        if (stretch_left == 0) begin
            free_running = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        pop <= free_running || ($urandom_range(0, 99) < 55);
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_decodes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- input side ----------------

    // Send one byte; bursts of random length separated by random gaps
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push   <= 1'b1;
        i_data <= '{in_byte: b, in_last: last};
        do @(posedge i_clk); while (full);
        predict_decode(b, last);
        burst_left--;
        bytes_sent++;
        if (last) begin
            messages_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Stop sending and let every owed result arrive, then let the pipe settle
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pred_limit = value;
        limit_writes++;
    endtask

    function automatic logic [7:0] random_hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10) begin
            return 8'("0" + n);
        end
        return ($urandom_range(0, 1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    // Random message: mostly well-formed escapes and text, some broken escapes
    task automatic send_random_message();
        logic [7:0] msg[$];
        int         len;
        int         pick;
        len = $urandom_range(1, 20);
        while (msg.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                msg.push_back(C_CHAR_PCT);
                msg.push_back(random_hex_char());
                msg.push_back(random_hex_char());
            end else if (pick < 45) begin
                msg.push_back(C_CHAR_PLUS);
            end else if (pick < 70) begin
                msg.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 82) begin
                msg.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                msg.push_back(C_CHAR_PCT);
                msg.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 96) begin
                msg.push_back(C_CHAR_PCT);
                msg.push_back(random_hex_char());
                msg.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg.push_back(C_CHAR_PCT);
            end
        end
        for (int i = 0; i < len; i++) begin
            send_byte(msg[i], i == len - 1);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("+");
    endtask

    task automatic test_escapes();
        send_text("a+%41%6a%Ff%G%4z");
    endtask

    // Broken escapes at message end, including a step that yields three bytes
    task automatic test_flush();
        send_text("%");
        send_text("%A");
        send_text("%A%");
        send_text("%%");
    endtask

    task automatic test_limits();
        set_limit(16'd0);
        send_text("a");
        set_limit(16'd2);
        send_text("abc");
        set_limit(16'd1);
        send_text("%4");
        set_limit(C_MAX_OUT_RESET);
    endtask

    task automatic test_random();
        logic [15:0] limits[8];
        int          phase_start;
        limits = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd5, 16'($urandom_range(3, 16)),
                   16'hFFFE, 16'($urandom_range(0, 65535))};
        foreach (limits[i]) begin
            set_limit(limits[i]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) begin
                send_random_message();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_bytes();
        test_escapes();
        test_flush();
        test_limits();
        test_random();
        wait_drained();

        $display("Sent %0d bytes in %0d messages under %0d limit settings (0 and 65535 included)",
                 bytes_sent, messages_sent, limit_writes);
        $display("Checked %0d decoded results, %0d mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
